### rtl/core/ock_pkg.sv
// Shared types and constants for the omni chassis kinematics core.
// Holds the item structs, register indexes and the fixed inverse matrix.
// No dependencies.
`default_nettype none

package ock_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int VAL_W          = 32;
	localparam int Q_FRAC         = 16;
	localparam int NUM_WHEELS     = 4;
	localparam int NUM_AXES       = 3;
	localparam int RADIUS_W       = 31;
	localparam int COEFF_W        = 64;
	localparam int MAT_W          = 19;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIN_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS = 3'd5;

	localparam logic CMD_FWD = 1'b0;
	localparam logic CMD_INV = 1'b1;

	// body x, y, turn rows over wheels 0..3, signed Q3.16
	localparam logic signed [MAT_W-1:0] INV_MAT [NUM_AXES][NUM_WHEELS] = '{
		'{-19'sd25885,  19'sd25885,  19'sd25885, -19'sd25885},
		'{-19'sd24394, -19'sd18110,  19'sd18110,  19'sd24394},
		'{ 19'sd259156, 19'sd169184, 19'sd169184, 19'sd259156}
	};

	typedef struct packed {
		logic              cmd;
		logic signed [31:0] body_x;
		logic signed [31:0] body_y;
		logic signed [31:0] body_turn;
		logic signed [31:0] wheel_speed_0;
		logic signed [31:0] wheel_speed_1;
		logic signed [31:0] wheel_speed_2;
		logic signed [31:0] wheel_speed_3;
	} ock_in_t;

	typedef struct packed {
		logic signed [31:0] out_wheel_0;
		logic signed [31:0] out_wheel_1;
		logic signed [31:0] out_wheel_2;
		logic signed [31:0] out_wheel_3;
		logic signed [31:0] out_body_x;
		logic signed [31:0] out_body_y;
		logic signed [31:0] out_body_turn;
		logic               saturated;
	} ock_out_t;

endpackage

`default_nettype wire

### rtl/core/omni_chassis_kinematics_core.sv
// Four-wheel omni chassis kinematics, forward and inverse, signed Q16.16.
// Depends on ock_pkg and ock_round_sat.
//
//   channel | signals                              | moves
//   --------+--------------------------------------+----------------------------
//   in      | in_valid, in_ready, in_item          | ock_in_t command item
//   out     | out_valid, out_ready, out_item       | ock_out_t result item
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
// Five-stage pipeline: products, sums / radius scaling, forward rounding and
// inverse matrix products, matrix sums, final rounding into the output register.
// One item per cycle sustained while out_ready stays high; out_valid rises once the item reaches the output register.
// Each stage holds its item while the stage after it is full and stalled;
// bubbles collapse, so in_ready drops only when all five stages hold items and
// out_ready is low.
// arst_n clears the valid bits and the configuration registers to zero.
`default_nettype none

module omni_chassis_kinematics_core #(
	parameter int DATA_WIDTH = ock_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire ock_pkg::ock_in_t               in_item,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output ock_pkg::ock_out_t                   out_item,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ock_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ock_pkg::COEFF_W-1:0]    cfg_data
);
	import ock_pkg::*;

	localparam int PROD_W  = 64;
	localparam int FSUM_W  = PROD_W + 2;
	localparam int MPROD_W = VAL_W + MAT_W;
	localparam int MSUM_W  = MPROD_W + 2;
	localparam int NPROD   = 2 * NUM_WHEELS + 1;

	// configuration registers
	logic [COEFF_W-1:0]      coeff_q [NUM_WHEELS];
	logic signed [VAL_W-1:0] spin_gain_q;
	logic [RADIUS_W-1:0]     radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WHEELS; i++)
				coeff_q[i] <= '0;
			spin_gain_q <= '0;
			radius_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WHEEL_0:      coeff_q[0]  <= cfg_data;
				CFG_WHEEL_1:      coeff_q[1]  <= cfg_data;
				CFG_WHEEL_2:      coeff_q[2]  <= cfg_data;
				CFG_WHEEL_3:      coeff_q[3]  <= cfg_data;
				CFG_SPIN_GAIN:    spin_gain_q <= cfg_data[VAL_W-1:0];
				CFG_WHEEL_RADIUS: radius_q    <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and advance enables
	logic [4:0] vld;
	logic [4:0] adv;

	always_comb begin
		adv[4] = !vld[4] || out_ready;
		for (int k = 3; k >= 0; k--)
			adv[k] = !vld[k] || adv[k+1];
	end

	assign in_ready  = adv[0];
	assign out_valid = vld[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[0])
				vld[0] <= in_valid;
			for (int k = 1; k < 5; k++)
				if (adv[k])
					vld[k] <= vld[k-1];
		end
	end

	// stage 1: products. Forward: slot 2w is cx*x, 2w+1 is sy*y, last is spin*turn.
	// Inverse: slots 0..3 are wheel speed times radius.
	logic signed [VAL_W-1:0]  wspd [NUM_WHEELS];
	logic signed [VAL_W-1:0]  op_a [NPROD];
	logic signed [VAL_W-1:0]  op_b [NPROD];
	logic signed [PROD_W-1:0] prod_s1 [NPROD];
	logic                     cmd_s1;

	assign wspd[0] = in_item.wheel_speed_0;
	assign wspd[1] = in_item.wheel_speed_1;
	assign wspd[2] = in_item.wheel_speed_2;
	assign wspd[3] = in_item.wheel_speed_3;

	always_comb begin
		for (int w = 0; w < NUM_WHEELS; w++) begin
			op_a[2*w]   = coeff_q[w][COEFF_W-1:VAL_W];
			op_b[2*w]   = in_item.body_x;
			op_a[2*w+1] = coeff_q[w][VAL_W-1:0];
			op_b[2*w+1] = in_item.body_y;
		end
		op_a[NPROD-1] = spin_gain_q;
		op_b[NPROD-1] = in_item.body_turn;
		if (in_item.cmd == CMD_INV) begin
			for (int w = 0; w < NUM_WHEELS; w++) begin
				op_a[w] = wspd[w];
				op_b[w] = $signed({1'b0, radius_q});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cmd_s1 <= in_item.cmd;
			for (int p = 0; p < NPROD; p++)
				prod_s1[p] <= PROD_W'(op_a[p]) * PROD_W'(op_b[p]);
		end
	end

	// stage 2: forward three-term sums, inverse radius scaling
	logic signed [FSUM_W-1:0] fsum_s2 [NUM_WHEELS];
	logic signed [VAL_W-1:0]  scaled_s2 [NUM_WHEELS];
	logic                     isat_s2;
	logic                     cmd_s2;
	logic [VAL_W-1:0]         scaled_c [NUM_WHEELS];
	logic [NUM_WHEELS-1:0]    scaled_clip;

	for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_scale
		ock_round_sat #(
			.IN_W  (PROD_W),
			.SAT_W (VAL_W)
		) u_scale (
			.sum     (prod_s1[g]),
			.res     (scaled_c[g]),
			.clipped (scaled_clip[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cmd_s2  <= cmd_s1;
			isat_s2 <= |scaled_clip;
			for (int w = 0; w < NUM_WHEELS; w++) begin
				fsum_s2[w]   <= FSUM_W'(prod_s1[2*w]) + FSUM_W'(prod_s1[2*w+1])
					+ FSUM_W'(prod_s1[NPROD-1]);
				scaled_s2[w] <= $signed(scaled_c[w]);
			end
		end
	end

	// stage 3: forward rounding and clipping, inverse matrix products
	logic [VAL_W-1:0]          wheel_c [NUM_WHEELS];
	logic [NUM_WHEELS-1:0]     wheel_clip;
	logic [VAL_W-1:0]          wheel_s3 [NUM_WHEELS];
	logic                      fsat_s3;
	logic                      isat_s3;
	logic                      cmd_s3;
	logic signed [MPROD_W-1:0] mprod_s3 [NUM_AXES][NUM_WHEELS];

	for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_fwd
		ock_round_sat #(
			.IN_W  (FSUM_W),
			.SAT_W (DATA_WIDTH)
		) u_fwd (
			.sum     (fsum_s2[g]),
			.res     (wheel_c[g]),
			.clipped (wheel_clip[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			cmd_s3  <= cmd_s2;
			isat_s3 <= isat_s2;
			fsat_s3 <= |wheel_clip;
			for (int w = 0; w < NUM_WHEELS; w++)
				wheel_s3[w] <= wheel_c[w];
			for (int r = 0; r < NUM_AXES; r++)
				for (int w = 0; w < NUM_WHEELS; w++)
					mprod_s3[r][w] <= MPROD_W'(INV_MAT[r][w]) * MPROD_W'(scaled_s2[w]);
		end
	end

	// stage 4: matrix row sums
	logic signed [MSUM_W-1:0] msum_s4 [NUM_AXES];
	logic [VAL_W-1:0]         wheel_s4 [NUM_WHEELS];
	logic                     fsat_s4;
	logic                     isat_s4;
	logic                     cmd_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			cmd_s4  <= cmd_s3;
			isat_s4 <= isat_s3;
			fsat_s4 <= fsat_s3;
			for (int w = 0; w < NUM_WHEELS; w++)
				wheel_s4[w] <= wheel_s3[w];
			for (int r = 0; r < NUM_AXES; r++)
				msum_s4[r] <= MSUM_W'(mprod_s3[r][0]) + MSUM_W'(mprod_s3[r][1])
					+ MSUM_W'(mprod_s3[r][2]) + MSUM_W'(mprod_s3[r][3]);
		end
	end

	// stage 5: body rounding and the output register
	logic [VAL_W-1:0]    body_c [NUM_AXES];
	logic [NUM_AXES-1:0] body_clip;
	ock_out_t            res_c;
	ock_out_t            out_s5;

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_inv
		ock_round_sat #(
			.IN_W  (MSUM_W),
			.SAT_W (DATA_WIDTH)
		) u_inv (
			.sum     (msum_s4[g]),
			.res     (body_c[g]),
			.clipped (body_clip[g])
		);
	end

	always_comb begin
		res_c = '0;
		if (cmd_s4 == CMD_INV) begin
			res_c.out_body_x    = $signed(body_c[0]);
			res_c.out_body_y    = $signed(body_c[1]);
			res_c.out_body_turn = $signed(body_c[2]);
			res_c.saturated     = isat_s4 || (|body_clip);
		end else begin
			res_c.out_wheel_0 = $signed(wheel_s4[0]);
			res_c.out_wheel_1 = $signed(wheel_s4[1]);
			res_c.out_wheel_2 = $signed(wheel_s4[2]);
			res_c.out_wheel_3 = $signed(wheel_s4[3]);
			res_c.saturated   = fsat_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4])
			out_s5 <= res_c;
	end

	assign out_item = out_s5;

endmodule

`default_nettype wire

### rtl/core/ock_round_sat.sv
// Round-half-up from Q32.32-style sums back to Q16.16, then clip to a signed width.
// Purely combinational; uses ock_pkg for the fraction and value widths.
`default_nettype none

module ock_round_sat #(
	parameter int IN_W  = 66,
	parameter int SAT_W = 32
) (
	input  wire logic signed [IN_W-1:0]           sum,
	output logic         [ock_pkg::VAL_W-1:0] res,
	output logic                                  clipped
);
	import ock_pkg::*;

	localparam int RW = IN_W + 1 - Q_FRAC;
	localparam int EW = ((RW > SAT_W) ? RW : SAT_W) + 1;
	localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [IN_W:0] HALF   = (IN_W+1)'(64'sd1 <<< (Q_FRAC - 1));

	logic signed [IN_W:0] biased;
	logic signed [IN_W:0] shifted;
	logic signed [EW-1:0] rounded;
	logic signed [EW-1:0] limited;

	always_comb begin
		biased  = (IN_W+1)'(sum) + HALF;
		shifted = biased >>> Q_FRAC;
		rounded = EW'(shifted);
		if (rounded > SAT_HI) begin
			limited = SAT_HI;
			clipped = 1'b1;
		end else if (rounded < SAT_LO) begin
			limited = SAT_LO;
			clipped = 1'b1;
		end else begin
			limited = rounded;
			clipped = 1'b0;
		end
		res = limited[VAL_W-1:0];
	end

endmodule

`default_nettype wire
